// File: design/dsrq_pkg.sv
// ----------------------------------------------------------------------------
// dsrq_pkg
// Types and constants shared by the duplicate-suppressing report queue.
// ----------------------------------------------------------------------------
package dsrq_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned CycW    = 32;
  localparam int unsigned RouteW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;
  localparam int unsigned MaxRes  = 16;

  localparam logic [1:0] ModeBoot   = 2'd0;
  localparam logic [1:0] ModeNormal = 2'd1;
  localparam logic [1:0] ModeClose  = 2'd2;

  localparam logic [1:0] RouteBoth    = 2'd0;
  localparam logic [1:0] RouteSerial  = 2'd1;
  localparam logic [1:0] RouteNetwork = 2'd2;

  localparam logic [1:0] KindStore = 2'd0;
  localparam logic [1:0] KindEntry = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  localparam logic [CfgIdxW-1:0] RegMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHold  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDrain = 2'd2;

  localparam logic [7:0] HoldReset  = 8'd1;
  localparam logic [4:0] DrainReset = 5'd11;

  typedef struct packed {
    logic                op;
    logic [RouteW-1:0]   route;
    logic [KeyW-1:0]     message_key;
    logic [CycW-1:0]     now_cycle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              serial_now;
    logic              stored;
    logic              duplicate;
    logic              dropped_full;
    logic              fail_notice;
    logic [KeyW-1:0]   out_key;
    logic [RouteW-1:0] out_route;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic win_rd;     // issue window read at scan pointer
    logic win_pop;    // retire oldest window entry
    logic scan_clr;   // restart window scan
    logic scan_step;  // advance window scan
    logic q_rd;       // issue queue read at head
    logic q_pop;      // pop queue head, emit entry
    logic commit;     // write queue/window for a store
    logic emit_store; // emit store status
    logic emit_empty; // emit empty marker
  } dsrq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic early;      // boot serial-only or close: store ends at once
    logic win_any;
    logic expired;    // head entry expired (valid after win read)
    logic scan_done;  // scan index reached window count
    logic key_hit;    // scanned entry matches
    logic q_any;
    logic drain_done; // pops reached the limit
  } dsrq_stat_t;

endpackage

// File: design/dsrq_if.sv
// ----------------------------------------------------------------------------
// dsrq_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dsrq_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/duplicate_suppressing_report_queue.sv
// ----------------------------------------------------------------------------
// duplicate_suppressing_report_queue
// Report queue with a time-windowed duplicate filter and bounded drain.
//
//   channel  dir  payload     beat
//   in_if    in   in_item_t   one store or drain request
//   out_if   out  out_item_t  one status, entry or empty marker
//   cfg      in   idx, data   register write, one cycle
//
// a store ends early in boot serial-only or close mode; otherwise it first
// retires expired window entries from the head, then scans the window for the
// key and commits. a drain pops queue entries up to the drain limit. reset
// clears all control state; memories need no clearing. a stalled output holds
// the sequencer.
// ----------------------------------------------------------------------------
module duplicate_suppressing_report_queue #(
  parameter int unsigned QUEUE_DEPTH  = 32,
  parameter int unsigned WINDOW_DEPTH = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsrq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsrq_pkg::CfgDatW-1:0]  cfg_data_i,
  dsrq_if.sink                          in_if,
  dsrq_if.source                        out_if
);
  import dsrq_pkg::*;

  dsrq_cmd_t  cmd;
  dsrq_stat_t stat;
  out_item_t  res;

  dsrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsrq_datapath #(.QueueDepth(QUEUE_DEPTH), .WindowDepth(WINDOW_DEPTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_dat_i (cfg_data_i),
    .item_i    (in_if.data),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (res)
  );

  assign out_if.data = res;
endmodule

// File: design/dsrq_ram.sv
// ----------------------------------------------------------------------------
// dsrq_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: design/dsrq_datapath.sv
// ----------------------------------------------------------------------------
// dsrq_datapath
// Item register, queue and window memories, pointers and result register.
// ----------------------------------------------------------------------------
module dsrq_datapath #(
  parameter int unsigned QueueDepth  = 32,
  parameter int unsigned WindowDepth = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dsrq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dsrq_pkg::CfgDatW-1:0] cfg_dat_i,
  input  dsrq_pkg::in_item_t          item_i,
  input  dsrq_pkg::dsrq_cmd_t         cmd_i,
  output dsrq_pkg::dsrq_stat_t        stat_o,
  output dsrq_pkg::out_item_t         res_o
);
  import dsrq_pkg::*;

  localparam int unsigned QAw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned WAw = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned QCw = $clog2(QueueDepth + 1);
  localparam int unsigned WCw = $clog2(WindowDepth + 1);

  logic [1:0]   mode_q;
  logic [7:0]   hold_q;
  logic [4:0]   drain_q;
  in_item_t     it_q;
  logic [CycW-1:0] prev_q;
  logic [QAw-1:0] qhead_q;
  logic [QCw-1:0] qcnt_q;
  logic [WAw-1:0] whead_q;
  logic [WCw-1:0] wcnt_q;
  logic [WCw-1:0] scan_q;
  logic [4:0]   npop_q;
  out_item_t    res_q;
  out_item_t    res_d;

  logic [KeyW-1:0]   wkey_rd, qkey_rd;
  logic [CycW-1:0]   wexp_rd;
  logic [RouteW-1:0] qroute_rd;
  logic [RouteW-1:0] eff_route;
  logic [4:0]   limit;
  logic         qfull, wfull;
  logic [WAw-1:0] whead_nx, wrd_addr, wwr_addr;
  logic [QAw-1:0] qtail;
  logic [WCw-1:0] wcnt_after;
  logic         do_rec;

  function automatic logic [WAw-1:0] wadd(input logic [WAw-1:0] a,
                                          input logic [WCw-1:0] b);
    logic [WAw+WCw:0] s;
    s = {{(WCw+1){1'b0}}, a} + {{(WAw+1){1'b0}}, b};
    if (s >= (WAw+WCw+1)'(WindowDepth)) begin
      s = s - (WAw+WCw+1)'(WindowDepth);
    end
    return s[WAw-1:0];
  endfunction

  function automatic logic [QAw-1:0] qadd(input logic [QAw-1:0] a,
                                          input logic [QCw-1:0] b);
    logic [QAw+QCw:0] s;
    s = {{(QCw+1){1'b0}}, a} + {{(QAw+1){1'b0}}, b};
    if (s >= (QAw+QCw+1)'(QueueDepth)) begin
      s = s - (QAw+QCw+1)'(QueueDepth);
    end
    return s[QAw-1:0];
  endfunction

  always_comb begin
    limit = drain_q;
    if (limit == 5'd0) limit = 5'd1;
    if (limit > 5'(MaxRes)) limit = 5'(MaxRes);
  end

  assign qfull   = (qcnt_q == QCw'(QueueDepth));
  assign wfull   = (wcnt_q == WCw'(WindowDepth));
  assign whead_nx = wadd(whead_q, WCw'(1));
  assign wrd_addr = wadd(whead_q, scan_q);
  assign qtail   = qadd(qhead_q, qcnt_q);
  assign do_rec  = cmd_i.commit && !stat_o.key_hit && (hold_q != 8'd0);
  // on overflow the oldest is evicted, tail lands on the old head slot
  assign wcnt_after = wfull ? (wcnt_q - WCw'(1)) : wcnt_q;
  assign wwr_addr = wfull ? whead_q : wadd(whead_q, wcnt_q);
  assign eff_route = (mode_q == ModeBoot) ? RouteNetwork : it_q.route;

  dsrq_ram #(.Width(KeyW + CycW), .Depth(WindowDepth)) u_win (
    .clk_i   (clk_i),
    .we_i    (do_rec),
    .waddr_i (wwr_addr),
    .wdata_i ({it_q.message_key, it_q.now_cycle + {24'd0, hold_q}}),
    .re_i    (cmd_i.win_rd),
    .raddr_i (wrd_addr),
    .rdata_o ({wkey_rd, wexp_rd})
  );

  dsrq_ram #(.Width(KeyW + RouteW), .Depth(QueueDepth)) u_que (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && !stat_o.key_hit && !qfull),
    .waddr_i (qtail),
    .wdata_i ({it_q.message_key, eff_route}),
    .re_i    (cmd_i.q_rd),
    .raddr_i (qhead_q),
    .rdata_o ({qkey_rd, qroute_rd})
  );

  always_comb begin
    stat_o.op         = it_q.op;
    stat_o.early      = (mode_q == ModeClose) ||
                        ((mode_q == ModeBoot) && (it_q.route == RouteSerial));
    stat_o.win_any    = (wcnt_q != '0);
    stat_o.expired    = (it_q.now_cycle >= wexp_rd);
    stat_o.scan_done  = (scan_q >= wcnt_q);
    stat_o.key_hit    = (wkey_rd == it_q.message_key) && !stat_o.scan_done;
    stat_o.q_any      = (qcnt_q != '0);
    stat_o.drain_done = (npop_q >= limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBoot;
      hold_q  <= HoldReset;
      drain_q <= DrainReset;
      prev_q  <= '0;
      qhead_q <= '0;
      qcnt_q  <= '0;
      whead_q <= '0;
      wcnt_q  <= '0;
      scan_q  <= '0;
      npop_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMode:  mode_q  <= cfg_dat_i[1:0];
          RegHold:  hold_q  <= cfg_dat_i;
          RegDrain: drain_q <= cfg_dat_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.load) npop_q <= '0;
      if (cmd_i.win_pop) begin
        whead_q <= whead_nx;
        wcnt_q  <= wcnt_q - WCw'(1);
      end
      if (cmd_i.scan_clr) scan_q <= '0;
      else if (cmd_i.scan_step) scan_q <= scan_q + WCw'(1);
      if (cmd_i.q_pop) begin
        qhead_q <= qadd(qhead_q, QCw'(1));
        qcnt_q  <= qcnt_q - QCw'(1);
        npop_q  <= npop_q + 5'd1;
      end
      if (cmd_i.commit) begin
        prev_q <= it_q.now_cycle;
        if (!stat_o.key_hit && !qfull) qcnt_q <= qcnt_q + QCw'(1);
        if (do_rec) begin
          if (wfull) whead_q <= whead_nx;
          wcnt_q <= wcnt_after + WCw'(1);
        end
      end
    end
  end

  always_comb begin
    res_d = '0;
    if (cmd_i.q_pop) begin
      res_d.kind      = KindEntry;
      res_d.out_key   = qkey_rd;
      res_d.out_route = qroute_rd;
      res_d.last      = (npop_q + 5'd1 == limit);
    end else if (cmd_i.emit_empty) begin
      res_d.kind = KindEmpty;
      res_d.last = 1'b1;
    end else if (cmd_i.emit_store) begin
      res_d.kind       = KindStore;
      res_d.last       = 1'b1;
      res_d.serial_now = (mode_q == ModeBoot || mode_q == ModeClose) &&
                         (it_q.route != RouteNetwork);
      if (!stat_o.early) begin
        res_d.duplicate    = stat_o.key_hit;
        res_d.stored       = !stat_o.key_hit && !qfull;
        res_d.dropped_full = !stat_o.key_hit && qfull;
        res_d.fail_notice  = !stat_o.key_hit && qfull &&
                             (prev_q != it_q.now_cycle);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    if (cmd_i.q_pop || cmd_i.emit_empty || cmd_i.emit_store) res_q <= res_d;
  end

  assign res_o = res_q;
endmodule

// File: design/dsrq_ctrl.sv
// ----------------------------------------------------------------------------
// dsrq_ctrl
// Sequencer: expiry walk, window scan, commit, drain pops, output handshake.
// ----------------------------------------------------------------------------
module dsrq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dsrq_pkg::dsrq_stat_t stat_i,
  output dsrq_pkg::dsrq_cmd_t  cmd_o
);
  import dsrq_pkg::*;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StDecide = 9'b000000010,
    StExpRd  = 9'b000000100,
    StExpChk = 9'b000001000,
    StScanRd = 9'b000010000,
    StScanCk = 9'b000100000,
    StQRd    = 9'b001000000,
    StQPop   = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   more_q, more_d; // drain continues after this beat

  always_comb begin
    state_d    = state_q;
    more_d     = more_q;
    cmd_o      = '0;
    in_ready_o = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          // first expiry read must see the head, not a stale scan index
          cmd_o.scan_clr = 1'b1;
          state_d        = StDecide;
        end
      end
      StDecide: begin
        if (stat_i.op) begin
          state_d = StQRd;
        end else if (stat_i.early) begin
          cmd_o.emit_store = 1'b1;
          state_d = StOut;
        end else begin
          state_d = StExpRd;
        end
      end
      StExpRd: begin
        cmd_o.scan_clr = 1'b1;
        if (stat_i.win_any) begin
          cmd_o.win_rd = 1'b1;
          state_d = StExpChk;
        end else begin
          state_d = StScanRd;
        end
      end
      StExpChk: begin
        if (stat_i.expired) begin
          cmd_o.win_pop = 1'b1;
          state_d = StExpRd;
        end else begin
          state_d = StScanRd;
        end
      end
      StScanRd: begin
        cmd_o.win_rd = 1'b1;
        state_d = StScanCk;
      end
      StScanCk: begin
        if (stat_i.key_hit || stat_i.scan_done) begin
          cmd_o.commit     = 1'b1;
          cmd_o.emit_store = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = StScanRd;
        end
      end
      StQRd: begin
        if (stat_i.drain_done) begin
          state_d = StIdle;
        end else if (stat_i.q_any) begin
          cmd_o.q_rd = 1'b1;
          state_d = StQPop;
        end else begin
          cmd_o.emit_empty = 1'b1;
          more_d  = 1'b0;
          state_d = StOut;
        end
      end
      StQPop: begin
        cmd_o.q_pop = 1'b1;
        more_d  = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = more_q ? StQRd : StIdle;
          more_d  = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
    end
  end
endmodule
